>>> sv/rpc_pkg.sv
// Shared constants for the point rotation block: widths, angle limits, CORDIC tables.
package rpc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_STAGES_DEF = 24;

    localparam int ANGLE_WIDTH  = 26;
    localparam int RED_WIDTH    = 25;
    localparam int MAG_WIDTH    = 22;
    localparam int CORDIC_WIDTH = 34;
    localparam int TRIG_WIDTH   = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 2'd2;

    localparam int DEG_45  = 2949120;
    localparam int DEG_90  = 5898240;
    localparam int DEG_135 = 8847360;
    localparam int DEG_180 = 11796480;
    localparam int DEG_225 = 14745600;
    localparam int DEG_270 = 17694720;
    localparam int DEG_315 = 20643840;
    localparam int DEG_360 = 23592960;

    localparam int ONE_Q30         = 1073741824;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    localparam int RPD_SPLIT = 20;
    localparam logic [40:0] RAD_PER_DEG_Q46 = 41'd1228166276394;

    localparam logic signed [TRIG_WIDTH-1:0] ATAN_ROM [32] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
        32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
        32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
        32'sd1023,      32'sd511,       32'sd255,       32'sd127,
        32'sd63,        32'sd31,        32'sd15,        32'sd7,
        32'sd3,         32'sd1,         32'sd0,         32'sd0
    };

endpackage

>>> sv/rotate_point_about_center.sv
// Pipelined rotation of integer points about a configured center by a configured angle.
// Throughput: one item per cycle; the whole pipeline, bubbles included, holds while the
// output register is full and not taken.
// Depth is set by the CORDIC chain, one micro-rotation per stage.
// Reset clears the valid bits and the center and angle registers; no clearing pass.
module rotate_point_about_center #(
    parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_STAGES = rpc_pkg::TRIG_STAGES_DEF,
    localparam int CFG_DW = (COORD_WIDTH > rpc_pkg::ANGLE_WIDTH) ?
                            COORD_WIDTH : rpc_pkg::ANGLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DW-1:0]                   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_point_x,
    input  logic signed [COORD_WIDTH-1:0]       i_point_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [COORD_WIDTH-1:0]       o_rotated_x,
    output logic signed [COORD_WIDTH-1:0]       o_rotated_y,
    output logic                                o_clipped
);
    import rpc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int DL  = (W + 2) / 2;
    localparam int HW  = DW - DL;
    localparam int T   = TRIG_STAGES;
    localparam int XW  = CORDIC_WIDTH;
    localparam int ZW  = TRIG_WIDTH;
    localparam int AW  = ANGLE_WIDTH + 1;
    localparam int RW  = RED_WIDTH + 2;
    localparam int PHW = HW + ZW;
    localparam int PLW = DL + 1 + ZW;
    localparam int SHW = PHW + 1;
    localparam int SLW = PLW + 2;
    localparam int TW  = W + 35;
    localparam int OW  = TW - 30;
    localparam int VW  = OW + 1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic signed [AW-1:0] A360  = AW'(DEG_360);
    localparam logic signed [AW-1:0] A720  = AW'(2 * DEG_360);
    localparam logic signed [AW-1:0] A360N = AW'(-DEG_360);

    localparam logic signed [RW-1:0] R45  = RW'(DEG_45);
    localparam logic signed [RW-1:0] R90  = RW'(DEG_90);
    localparam logic signed [RW-1:0] R135 = RW'(DEG_135);
    localparam logic signed [RW-1:0] R180 = RW'(DEG_180);
    localparam logic signed [RW-1:0] R225 = RW'(DEG_225);
    localparam logic signed [RW-1:0] R270 = RW'(DEG_270);
    localparam logic signed [RW-1:0] R315 = RW'(DEG_315);
    localparam logic signed [RW-1:0] R360 = RW'(DEG_360);

    localparam logic [RPD_SPLIT:0]   K_HI = RAD_PER_DEG_Q46[40:RPD_SPLIT];
    localparam logic [RPD_SPLIT-1:0] K_LO = RAD_PER_DEG_Q46[RPD_SPLIT-1:0];
    localparam logic [63:0]          Z_HALF = 64'd2147483648;

    localparam logic signed [XW-1:0] X_ONE  = XW'(ONE_Q30);
    localparam logic signed [XW-1:0] X_ONEN = XW'(-ONE_Q30);
    localparam logic signed [XW-1:0] X_GAIN = XW'(CORDIC_GAIN_Q30);
    localparam logic signed [ZW-1:0] T_ONE  = ZW'(ONE_Q30);
    localparam logic signed [SLW-1:0] HALF_Q30 = SLW'(ONE_Q30 / 2);

    localparam logic signed [VW-1:0] SAT_MAX = $signed({7'b0, {(W-1){1'b1}}});
    localparam logic signed [VW-1:0] SAT_MIN = $signed({7'h7f, {(W-1){1'b0}}});

    logic signed [W-1:0]           r_center_x;
    logic signed [W-1:0]           r_center_y;
    logic signed [ANGLE_WIDTH-1:0] r_angle;

    logic en;
    logic r_v1, r_v2, r_v3, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_cv [0:T];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_angle    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= i_cfg_data[W-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[W-1:0];
                CFG_ANGLE:    r_angle    <= i_cfg_data[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign en          = !r_v9 || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int k = 0; k <= T; k++) begin
                r_cv[k] <= 1'b0;
            end
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_cv[0] <= r_v3;
            for (int k = 0; k < T; k++) begin
                r_cv[k+1] <= r_cv[k];
            end
            r_v5 <= r_cv[T];
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    // stage 1: wrap angle into one turn, form offsets from the center
    logic signed [AW-1:0]   ang_ext, n_red_full;
    logic [RED_WIDTH-1:0]   r_red1;
    logic signed [DW-1:0]   r_dx1, r_dy1;

    always_comb begin
        ang_ext = {r_angle[ANGLE_WIDTH-1], r_angle};
        if (ang_ext < A360N) begin
            n_red_full = ang_ext + A720;
        end else if (ang_ext < 0) begin
            n_red_full = ang_ext + A360;
        end else if (ang_ext >= A360) begin
            n_red_full = ang_ext - A360;
        end else begin
            n_red_full = ang_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red1 <= n_red_full[RED_WIDTH-1:0];
            r_dx1  <= {i_point_x[W-1], i_point_x} - {r_center_x[W-1], r_center_x};
            r_dy1  <= {i_point_y[W-1], i_point_y} - {r_center_y[W-1], r_center_y};
        end
    end

    // stage 2: quarter turns and residual
    logic signed [RW-1:0]  red_s, n_res, n_res_neg;
    logic [1:0]            n_quad;
    logic [1:0]            r_quad2;
    logic                  r_neg2, r_zres2;
    logic [MAG_WIDTH-1:0]  r_mag2;
    logic signed [DW-1:0]  r_dx2, r_dy2;

    always_comb begin
        red_s = $signed({2'b00, r_red1});
        if (red_s < R45) begin
            n_quad = QUAD_0;
            n_res  = red_s;
        end else if (red_s < R135) begin
            n_quad = QUAD_1;
            n_res  = red_s - R90;
        end else if (red_s < R225) begin
            n_quad = QUAD_2;
            n_res  = red_s - R180;
        end else if (red_s < R315) begin
            n_quad = QUAD_3;
            n_res  = red_s - R270;
        end else begin
            n_quad = QUAD_0;
            n_res  = red_s - R360;
        end
        n_res_neg = -n_res;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quad2 <= n_quad;
            r_neg2  <= n_res[RW-1];
            r_zres2 <= (n_res == '0);
            r_mag2  <= n_res[RW-1] ? n_res_neg[MAG_WIDTH-1:0] : n_res[MAG_WIDTH-1:0];
            r_dx2   <= r_dx1;
            r_dy2   <= r_dy1;
        end
    end

    // stage 3: degrees to radians, split into two partial products
    logic [MAG_WIDTH+RPD_SPLIT:0]   r_pph3;
    logic [MAG_WIDTH+RPD_SPLIT-1:0] r_ppl3;
    logic [1:0]                     r_quad3;
    logic                           r_neg3, r_zres3;
    logic signed [DW-1:0]           r_dx3, r_dy3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pph3  <= r_mag2 * K_HI;
            r_ppl3  <= r_mag2 * K_LO;
            r_quad3 <= r_quad2;
            r_neg3  <= r_neg2;
            r_zres3 <= r_zres2;
            r_dx3   <= r_dx2;
            r_dy3   <= r_dy2;
        end
    end

    // stage 4: round the angle and seed the CORDIC
    logic [63:0]            zsum;
    logic signed [ZW-1:0]   zpos;
    logic signed [XW-1:0]   r_cx  [0:T];
    logic signed [XW-1:0]   r_cy  [0:T];
    logic signed [ZW-1:0]   r_cz  [0:T-1];
    logic [1:0]             r_cq  [0:T];
    logic                   r_czr [0:T];
    logic signed [DW-1:0]   r_cdx [0:T];
    logic signed [DW-1:0]   r_cdy [0:T];

    always_comb begin
        zsum = {1'b0, r_pph3, {RPD_SPLIT{1'b0}}} + 64'(r_ppl3) + Z_HALF;
        zpos = $signed({1'b0, zsum[62:32]});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0]  <= X_GAIN;
            r_cy[0]  <= '0;
            r_cz[0]  <= r_neg3 ? -zpos : zpos;
            r_cq[0]  <= r_quad3;
            r_czr[0] <= r_zres3;
            r_cdx[0] <= r_dx3;
            r_cdy[0] <= r_dy3;
        end
    end

    for (genvar k = 0; k < T; k++) begin : g_cordic
        logic signed [XW-1:0] xs, ys, nx, ny;

        always_comb begin
            xs = r_cx[k] >>> k;
            ys = r_cy[k] >>> k;
            if (!r_cz[k][ZW-1]) begin
                nx = r_cx[k] - ys;
                ny = r_cy[k] + xs;
            end else begin
                nx = r_cx[k] + ys;
                ny = r_cy[k] - xs;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[k+1]  <= nx;
                r_cy[k+1]  <= ny;
                r_cq[k+1]  <= r_cq[k];
                r_czr[k+1] <= r_czr[k];
                r_cdx[k+1] <= r_cdx[k];
                r_cdy[k+1] <= r_cdy[k];
            end
        end

        if (k < T - 1) begin : g_angle
            logic signed [ZW-1:0] nz;

            always_comb begin
                if (!r_cz[k][ZW-1]) begin
                    nz = r_cz[k] - ATAN_ROM[k];
                end else begin
                    nz = r_cz[k] + ATAN_ROM[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cz[k+1] <= nz;
                end
            end
        end
    end

    // stage 5: clamp, exact quarter turns
    logic signed [ZW-1:0]  c0, s0, n_c, n_s;
    logic signed [ZW-1:0]  r_c5, r_s5, r_ns5;
    logic signed [DW-1:0]  r_dx5, r_dy5;

    always_comb begin
        if (r_cx[T] > X_ONE) begin
            c0 = T_ONE;
        end else if (r_cx[T] < X_ONEN) begin
            c0 = -T_ONE;
        end else begin
            c0 = r_cx[T][ZW-1:0];
        end
        if (r_cy[T] > X_ONE) begin
            s0 = T_ONE;
        end else if (r_cy[T] < X_ONEN) begin
            s0 = -T_ONE;
        end else begin
            s0 = r_cy[T][ZW-1:0];
        end
        if (r_czr[T]) begin
            c0 = T_ONE;
            s0 = '0;
        end
        case (r_cq[T])
            QUAD_1: begin
                n_c = -s0;
                n_s = c0;
            end
            QUAD_2: begin
                n_c = -c0;
                n_s = -s0;
            end
            QUAD_3: begin
                n_c = s0;
                n_s = -c0;
            end
            default: begin
                n_c = c0;
                n_s = s0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c5  <= n_c;
            r_s5  <= n_s;
            r_ns5 <= -n_s;
            r_dx5 <= r_cdx[T];
            r_dy5 <= r_cdy[T];
        end
    end

    // stage 6: partial products of offsets and trig factors
    logic signed [HW-1:0]   dx_hi, dy_hi;
    logic signed [DL:0]     dx_lo, dy_lo;
    logic signed [PHW-1:0]  r_hxc, r_hys, r_hxs, r_hyc;
    logic signed [PLW-1:0]  r_lxc, r_lys, r_lxs, r_lyc;

    assign dx_hi = r_dx5[DW-1:DL];
    assign dy_hi = r_dy5[DW-1:DL];
    assign dx_lo = $signed({1'b0, r_dx5[DL-1:0]});
    assign dy_lo = $signed({1'b0, r_dy5[DL-1:0]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hxc <= dx_hi * r_c5;
            r_lxc <= dx_lo * r_c5;
            r_hys <= dy_hi * r_ns5;
            r_lys <= dy_lo * r_ns5;
            r_hxs <= dx_hi * r_s5;
            r_lxs <= dx_lo * r_s5;
            r_hyc <= dy_hi * r_c5;
            r_lyc <= dy_lo * r_c5;
        end
    end

    // stage 7: sum high and low halves, add rounding half
    logic signed [SHW-1:0] r_shx, r_shy;
    logic signed [SLW-1:0] r_slx, r_sly;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_shx <= SHW'(r_hxc) + SHW'(r_hys);
            r_shy <= SHW'(r_hxs) + SHW'(r_hyc);
            r_slx <= SLW'(r_lxc) + SLW'(r_lys) + HALF_Q30;
            r_sly <= SLW'(r_lxs) + SLW'(r_lyc) + HALF_Q30;
        end
    end

    // stage 8: combine halves, drop fraction
    logic signed [TW-1:0] totx, toty;
    logic signed [OW-1:0] r_dlx, r_dly;

    always_comb begin
        totx = (TW'(r_shx) <<< DL) + TW'(r_slx);
        toty = (TW'(r_shy) <<< DL) + TW'(r_sly);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dlx <= $signed(totx[TW-1:30]);
            r_dly <= $signed(toty[TW-1:30]);
        end
    end

    // stage 9: add center, saturate
    logic signed [VW-1:0] vx, vy;
    logic signed [W-1:0]  n_ox, n_oy;
    logic                 n_clip;
    logic signed [W-1:0]  r_out_x, r_out_y;
    logic                 r_clip;

    always_comb begin
        vx     = VW'(r_center_x) + VW'(r_dlx);
        vy     = VW'(r_center_y) + VW'(r_dly);
        n_clip = 1'b0;
        if (vx > SAT_MAX) begin
            n_ox   = SAT_MAX[W-1:0];
            n_clip = 1'b1;
        end else if (vx < SAT_MIN) begin
            n_ox   = SAT_MIN[W-1:0];
            n_clip = 1'b1;
        end else begin
            n_ox = vx[W-1:0];
        end
        if (vy > SAT_MAX) begin
            n_oy   = SAT_MAX[W-1:0];
            n_clip = 1'b1;
        end else if (vy < SAT_MIN) begin
            n_oy   = SAT_MIN[W-1:0];
            n_clip = 1'b1;
        end else begin
            n_oy = vy[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= n_ox;
            r_out_y <= n_oy;
            r_clip  <= n_clip;
        end
    end

    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;
    assign o_clipped   = r_clip;

endmodule

>>> sv/rpc_checker.sv
// Port-level assertions for the point rotation block and the bind that attaches them.
module rpc_checker #(
    parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_WIDTH-1:0] o_rotated_x,
    input logic signed [COORD_WIDTH-1:0] o_rotated_y,
    input logic                          o_clipped
);
    localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_rotated_x) && $stable(o_rotated_y) && $stable(o_clipped)))
        else $error("output payload changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with empty output register");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline is stalled");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_rotated_x == SAT_MAX || o_rotated_x == SAT_MIN ||
             o_rotated_y == SAT_MAX || o_rotated_y == SAT_MIN))
        else $error("clip flag set without a saturated coordinate");

endmodule

bind rotate_point_about_center rpc_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_rpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_rotated_x (o_rotated_x),
    .o_rotated_y (o_rotated_y),
    .o_clipped   (o_clipped)
);

>>> verif/rpc_rotation_checker.sv
// Checker for the point rotation block: predicts each rotated point and compares results.
module rpc_rotation_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [31:0]            i_point_x,
    input  logic signed [31:0]            i_point_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [31:0]            i_rotated_x,
    input  logic signed [31:0]            i_rotated_y,
    input  logic                          i_clipped,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TURN_Q16    = 23592960;
    localparam longint EIGHTH_Q16  = 2949120;
    localparam longint QUARTER_Q16 = 5898240;
    localparam longint UNITY_Q30   = 1073741824;
    localparam longint GAIN_Q30    = 652032874;
    localparam longint unsigned RAD_PER_DEG_Q46 = 64'd1228166276394;
    localparam int     STAGES      = 24;
    localparam longint SAT_HI      = 2147483647;
    localparam longint SAT_LO      = -SAT_HI - 1;

    localparam longint ARCTAN_Q30 [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               clip;
    } rotated_t;

    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [25:0] angle_q16;
    rotated_t           rotated_q[$];
    int                 fails = 0;

    assign o_fail_count = fails;

    function automatic void cos_sin_q30(input longint resid, output longint c,
                                        output longint s);
        longint unsigned mag;
        longint unsigned zmag;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        int              i;
        if (resid == 0) begin
            c = UNITY_Q30;
            s = 0;
            return;
        end
        mag  = (resid < 0) ? -resid : resid;
        zmag = (mag * RAD_PER_DEG_Q46 + (64'd1 << 31)) >> 32;
        z    = (resid < 0) ? -longint'(zmag) : longint'(zmag);
        x    = GAIN_Q30;
        y    = 0;
        for (i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q30[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q30[i];
            end
        end
        if (x > UNITY_Q30) x = UNITY_Q30;
        if (x < -UNITY_Q30) x = -UNITY_Q30;
        if (y > UNITY_Q30) y = UNITY_Q30;
        if (y < -UNITY_Q30) y = -UNITY_Q30;
        c = x;
        s = y;
    endfunction

    // floor((a*p + b*q) / 2^30 + 1/2), exact
    function automatic longint mul_round(input longint a, input longint p,
                                         input longint b, input longint q);
        logic signed [95:0] acc;
        acc = 96'(a) * 96'(p) + 96'(b) * 96'(q) + 96'sd536870912;
        return longint'(acc >>> 30);
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v, inout logic clip);
        if (v > SAT_HI) begin
            clip = 1'b1;
            return 32'(SAT_HI);
        end
        if (v < SAT_LO) begin
            clip = 1'b1;
            return 32'(SAT_LO);
        end
        return 32'(v);
    endfunction

    function automatic rotated_t rotate_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py);
        longint   ang;
        longint   red;
        longint   quad;
        longint   c0;
        longint   s0;
        longint   c;
        longint   s;
        longint   dx;
        longint   dy;
        rotated_t r;
        ang    = longint'(angle_q16);
        r.clip = 1'b0;
        if (ang == 0) begin
            r.x = px;
            r.y = py;
            return r;
        end
        red  = ((ang % TURN_Q16) + TURN_Q16) % TURN_Q16;
        quad = (red + EIGHTH_Q16) / QUARTER_Q16;
        cos_sin_q30(red - quad * QUARTER_Q16, c0, s0);
        case (quad & 3)
            1: begin
                c = -s0;
                s = c0;
            end
            2: begin
                c = -c0;
                s = -s0;
            end
            3: begin
                c = s0;
                s = -c0;
            end
            default: begin
                c = c0;
                s = s0;
            end
        endcase
        dx  = longint'(px) - longint'(center_x);
        dy  = longint'(py) - longint'(center_y);
        r.x = clamp_coord(longint'(center_x) + mul_round(dx, c, dy, -s), r.clip);
        r.y = clamp_coord(longint'(center_y) + mul_round(dx, s, dy, c), r.clip);
        return r;
    endfunction

    always @(posedge i_clk) begin
        rotated_t want;
        if (!i_rst_n) begin
            center_x  = '0;
            center_y  = '0;
            angle_q16 = '0;
            rotated_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpc_pkg::CFG_CENTER_X: center_x  = i_cfg_data[31:0];
                    rpc_pkg::CFG_CENTER_Y: center_y  = i_cfg_data[31:0];
                    rpc_pkg::CFG_ANGLE:    angle_q16 = i_cfg_data[25:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                rotated_q.push_back(rotate_point(i_point_x, i_point_y));
            if (i_out_valid && i_out_ready) begin
                if (rotated_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result x=%0d y=%0d clipped=%0b",
                             $time, i_rotated_x, i_rotated_y, i_clipped);
                end else begin
                    want = rotated_q.pop_front();
                    if (i_rotated_x !== want.x) begin
                        fails++;
                        $display("%0t: rotated_x expected %0d got %0d",
                                 $time, want.x, i_rotated_x);
                    end
                    if (i_rotated_y !== want.y) begin
                        fails++;
                        $display("%0t: rotated_y expected %0d got %0d",
                                 $time, want.y, i_rotated_y);
                    end
                    if (i_clipped !== want.clip) begin
                        fails++;
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.clip, i_clipped);
                    end
                end
            end
        end
        o_pending = rotated_q.size();
    end

endmodule

>>> verif/tb_rotate_point_about_center.sv
// Testbench top for the point rotation block: clock, reset, stimulus, stalls and verdict.
module tb_rotate_point_about_center;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 128;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [rpc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]                   i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [31:0]            i_point_x;
    logic signed [31:0]            i_point_y;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [31:0]            o_rotated_x;
    logic signed [31:0]            o_rotated_y;
    logic                          o_clipped;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int hold_seq = 0;

    rotate_point_about_center dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rotated_x (o_rotated_x),
        .o_rotated_y (o_rotated_y),
        .o_clipped   (o_clipped)
    );

    rpc_rotation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_rotated_x  (o_rotated_x),
        .i_rotated_y  (o_rotated_y),
        .i_clipped    (o_clipped),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int hold_seen;
        hold_seen   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [31:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_center();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return extreme_coord();
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    function automatic int pick_angle();
        int k;
        case ($urandom_range(0, 5))
            1: begin
                k = int'($urandom_range(0, 8)) - 4;
                return k * rpc_pkg::DEG_90;
            end
            2: return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 64));
            3: return ($urandom_range(0, 1) ? 1 : -1) *
                      (rpc_pkg::DEG_360 - int'($urandom_range(0, 1)));
            4: begin
                k = int'($urandom_range(0, 16)) - 8;
                return k * rpc_pkg::DEG_45 + int'($urandom_range(0, 4)) - 2;
            end
            default: return int'($urandom_range(0, 2 * rpc_pkg::DEG_360)) - rpc_pkg::DEG_360;
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high after the item
    task automatic push_point(input logic signed [31:0] x, input logic signed [31:0] y);
        while (!calm && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x  <= x;
        i_point_y  <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic signed [31:0] cx, input logic signed [31:0] cy,
                              input int angle);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rpc_pkg::CFG_CENTER_X;
        i_cfg_data <= cx;
        @(negedge i_clk);
        i_cfg_idx  <= rpc_pkg::CFG_CENTER_Y;
        i_cfg_data <= cy;
        @(negedge i_clk);
        i_cfg_idx  <= rpc_pkg::CFG_ANGLE;
        i_cfg_data <= angle;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int                 phase;
        int                 n;
        int                 span;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = rpc_pkg::CFG_CENTER_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_point_x  = '0;
        i_point_y  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero angle after reset: pass through
        push_point(COORD_MIN, COORD_MAX);
        push_point(COORD_MAX, COORD_MIN);
        push_point(0, 0);
        set_config(0, 0, rpc_pkg::DEG_90);
        push_point(COORD_MIN, COORD_MIN);
        push_point(COORD_MAX, COORD_MAX);
        push_point(1, 2);
        set_config(COORD_MAX, COORD_MIN, rpc_pkg::DEG_180);
        push_point(COORD_MIN, COORD_MAX);
        push_point(COORD_MAX, COORD_MIN);
        set_config(-5, 7, -rpc_pkg::DEG_360);
        push_point(12345, -678);
        set_config(COORD_MIN, COORD_MAX, rpc_pkg::DEG_360);
        push_point(COORD_MAX, COORD_MIN);
        set_config(0, 0, rpc_pkg::DEG_45);
        push_point(COORD_MAX, COORD_MAX);
        push_point(1000, 0);
        push_point(-1, -1);
        set_config(100, -100, 1);
        push_point(COORD_MAX, 0);
        set_config(0, 0, -1);
        push_point(0, COORD_MIN);
        set_config(3, 4, rpc_pkg::DEG_270 + 12345);
        push_point(-77, 88);
        set_config(0, 0, -rpc_pkg::DEG_45);
        push_point(COORD_MIN, 0);
        push_point(-1000, 999);

        for (phase = 0; phase < PHASES; phase++) begin
            cx = pick_center();
            cy = pick_center();
            set_config(cx, cy, pick_angle());
            calm <= (phase == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 6 && n == 40)
                    hold_seq <= hold_seq + 1;
                if (phase == 7 && n == 60)
                    drain();
                case ($urandom_range(0, 9))
                    0, 1: push_point($urandom, $urandom);
                    2: push_point(extreme_coord(), extreme_coord());
                    default: begin
                        span = 1 << $urandom_range(1, 24);
                        push_point(cx + int'($urandom_range(0, 2 * span)) - span,
                                   cy + int'($urandom_range(0, 2 * span)) - span);
                    end
                endcase
            end
        end
        calm <= 1'b0;
        drain();

        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
